// ----- rtl/core/volume_profile_value_area_assert.svh -----
// Assertion macros shared by the checkers of the volume profile block.
// Depends on nothing; every macro expects signals named clock and reset.
`ifndef VOLUME_PROFILE_VALUE_AREA_ASSERT_SVH
`define VOLUME_PROFILE_VALUE_AREA_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define VPVA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("volume profile check failed");

// Next-cycle implication, disabled while reset is high.
`define VPVA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("volume profile check failed");

`endif

// ----- rtl/core/vpva_pkg.sv -----
// Package for the volume profile value area block: widths, codes, types and helpers.
// Depends on nothing; used by every module of the block.
package vpva_pkg;

   localparam int TICK_W         = 20;
   localparam int COUNT_IN_W     = 9;
   localparam int VOL_W          = 32;
   localparam int LVL_W          = 40;
   localparam int SUM_W          = 48;
   localparam int DROP_W         = 16;
   localparam int PCT_W          = 7;
   localparam int PROD_W         = SUM_W + PCT_W;
   localparam int MAX_LEVELS_DEF = 256;

   localparam logic [PCT_W-1:0] PCT_RESET = 7'd70;
   localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;

   // Command codes carried by an input transaction.
   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Control sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_EX_RD,
      ST_EX_STEP,
      ST_OUT
   } state_type;

   // Commands from the sequencer to the accumulation pipeline.
   typedef struct packed {
      logic add;
      logic clear;
   } acc_cmd_type;

   // Level update saturating at the largest 40-bit value.
   function automatic logic [LVL_W-1:0] sat_level_add(input logic [LVL_W-1:0] a,
                                                       input logic [VOL_W-1:0] b);
      logic [LVL_W:0] s;
      s = {1'b0, a} + (LVL_W + 1)'(b);
      return s[LVL_W] ? {LVL_W{1'b1}} : s[LVL_W-1:0];
   endfunction

   // Sum update saturating at the largest 48-bit value.
   function automatic logic [SUM_W-1:0] sat_sum_add(input logic [SUM_W-1:0] a,
                                                     input logic [LVL_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + (SUM_W + 1)'(b);
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

endpackage

// ----- rtl/core/volume_profile_value_area.sv -----
// Top level of the volume profile block: point of control and value area over a tick window.
// Depends on vpva_pkg, vpva_hist_mem, vpva_accum and vpva_ctrl.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  command, price_tick, level_count, volume
//   rsp_      out        rsp_valid/rsp_stall  poc, area bounds, volumes, dropped, empty
//   csr_      in         csr_write_enable     value_area_percent
//
// An add transaction is taken every cycle while the sequencer is idle; its level is read,
// and written back in the next cycle, through the histogram store, with forwarding between
// back-to-back adds to one level. A start is followed by a clearing sweep that zeroes every
// window level. A finish scans the window for the first maximum, grows the value area one
// level per read-and-step pass, makes a final check (skipped for an empty profile) and
// then loads the result register. While a result is held, adds continue.
// After reset a clearing pass zeroes level 0 before the first transaction is taken.
// A held result stops the next finish before its result load, stalling every request.
module volume_profile_value_area #(
   parameter int MAX_LEVELS = vpva_pkg::MAX_LEVELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [vpva_pkg::TICK_W-1:0]       req_price_tick,
   input  logic [vpva_pkg::COUNT_IN_W-1:0]   req_level_count,
   input  logic [vpva_pkg::VOL_W-1:0]        req_volume,
   input  logic                              csr_write_enable,
   input  logic [vpva_pkg::PCT_W-1:0]        csr_write_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vpva_pkg::TICK_W-1:0]       rsp_poc_tick,
   output logic [vpva_pkg::LVL_W-1:0]        rsp_poc_volume,
   output logic [vpva_pkg::TICK_W-1:0]       rsp_area_high_tick,
   output logic [vpva_pkg::TICK_W-1:0]       rsp_area_low_tick,
   output logic [vpva_pkg::SUM_W-1:0]        rsp_area_volume,
   output logic [vpva_pkg::SUM_W-1:0]        rsp_total_volume,
   output logic [vpva_pkg::DROP_W-1:0]       rsp_dropped_count,
   output logic                              rsp_empty_res
);

   localparam int IDX_W = $clog2(MAX_LEVELS);
   localparam int CNT_W = $clog2(MAX_LEVELS + 1);

   vpva_pkg::acc_cmd_type        acc_cmd;
   logic [vpva_pkg::TICK_W-1:0]  base;
   logic [CNT_W-1:0]             levels;
   logic [vpva_pkg::SUM_W-1:0]   running_total;
   logic [vpva_pkg::DROP_W-1:0]  dropped;
   logic [IDX_W-1:0]             add_rd_addr;
   logic                         add_wr_en;
   logic [IDX_W-1:0]             add_wr_addr;
   logic [vpva_pkg::LVL_W-1:0]   add_wr_data;
   logic                         mem_wr_en;
   logic [IDX_W-1:0]             mem_wr_addr;
   logic [vpva_pkg::LVL_W-1:0]   mem_wr_data;
   logic [IDX_W-1:0]             mem_rd_addr_a;
   logic [IDX_W-1:0]             mem_rd_addr_b;
   logic [vpva_pkg::LVL_W-1:0]   mem_rd_data_a;
   logic [vpva_pkg::LVL_W-1:0]   mem_rd_data_b;

   // Histogram store.
   vpva_hist_mem #(.MAX_LEVELS(MAX_LEVELS)) u_mem (
      .clock     (clock),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b)
   );

   // Add pipeline.
   vpva_accum #(.MAX_LEVELS(MAX_LEVELS)) u_accum (
      .clock         (clock),
      .reset         (reset),
      .acc_cmd       (acc_cmd),
      .tick          (req_price_tick),
      .volume        (req_volume),
      .base          (base),
      .levels        (levels),
      .rd_data       (mem_rd_data_a),
      .rd_addr       (add_rd_addr),
      .wr_en         (add_wr_en),
      .wr_addr       (add_wr_addr),
      .wr_data       (add_wr_data),
      .running_total (running_total),
      .dropped       (dropped)
   );

   // Sequencer and result register.
   vpva_ctrl #(.MAX_LEVELS(MAX_LEVELS)) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_price_tick     (req_price_tick),
      .req_level_count    (req_level_count),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .acc_cmd            (acc_cmd),
      .base               (base),
      .levels             (levels),
      .running_total      (running_total),
      .dropped            (dropped),
      .add_rd_addr        (add_rd_addr),
      .add_wr_en          (add_wr_en),
      .add_wr_addr        (add_wr_addr),
      .add_wr_data        (add_wr_data),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_addr_a      (mem_rd_addr_a),
      .mem_rd_addr_b      (mem_rd_addr_b),
      .mem_rd_data_a      (mem_rd_data_a),
      .mem_rd_data_b      (mem_rd_data_b),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_poc_tick       (rsp_poc_tick),
      .rsp_poc_volume     (rsp_poc_volume),
      .rsp_area_high_tick (rsp_area_high_tick),
      .rsp_area_low_tick  (rsp_area_low_tick),
      .rsp_area_volume    (rsp_area_volume),
      .rsp_total_volume   (rsp_total_volume),
      .rsp_dropped_count  (rsp_dropped_count),
      .rsp_empty_res      (rsp_empty_res)
   );

endmodule

// ----- rtl/core/vpva_hist_mem.sv -----
// Histogram store: one write port and two registered read ports.
// Depends on vpva_pkg for the level width.
module vpva_hist_mem #(
   parameter int MAX_LEVELS = vpva_pkg::MAX_LEVELS_DEF,
   localparam int IDX_W = $clog2(MAX_LEVELS)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  logic [vpva_pkg::LVL_W-1:0]   wr_data,
   input  logic [IDX_W-1:0]             rd_addr_a,
   input  logic [IDX_W-1:0]             rd_addr_b,
   output logic [vpva_pkg::LVL_W-1:0]   rd_data_a,
   output logic [vpva_pkg::LVL_W-1:0]   rd_data_b
);

   logic [vpva_pkg::LVL_W-1:0] mem [MAX_LEVELS];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports, registered; a read returns the value before a same-edge write.
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ----- rtl/core/vpva_accum.sv -----
// Add pipeline: window check, read-modify-write of one level with forwarding, totals.
// Depends on vpva_pkg for widths, the command struct and the saturating adders.
module vpva_accum #(
   parameter int MAX_LEVELS = vpva_pkg::MAX_LEVELS_DEF,
   localparam int IDX_W = $clog2(MAX_LEVELS),
   localparam int CNT_W = $clog2(MAX_LEVELS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vpva_pkg::acc_cmd_type         acc_cmd,
   input  logic [vpva_pkg::TICK_W-1:0]   tick,
   input  logic [vpva_pkg::VOL_W-1:0]    volume,
   input  logic [vpva_pkg::TICK_W-1:0]   base,
   input  logic [CNT_W-1:0]              levels,
   input  logic [vpva_pkg::LVL_W-1:0]    rd_data,
   output logic [IDX_W-1:0]              rd_addr,
   output logic                          wr_en,
   output logic [IDX_W-1:0]              wr_addr,
   output logic [vpva_pkg::LVL_W-1:0]    wr_data,
   output logic [vpva_pkg::SUM_W-1:0]    running_total,
   output logic [vpva_pkg::DROP_W-1:0]   dropped
);

   logic [vpva_pkg::TICK_W-1:0] offset;
   logic                        hit;

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_hit_ff;
   logic [IDX_W-1:0]             s1_idx_ff;
   logic [vpva_pkg::VOL_W-1:0]   s1_vol_ff;
   logic                         fwd_hit_ff, fwd_hit_in;
   logic [vpva_pkg::LVL_W-1:0]   fwd_data_ff;
   logic [vpva_pkg::LVL_W-1:0]   operand;
   logic [vpva_pkg::LVL_W-1:0]   level_sum;

   logic [vpva_pkg::SUM_W-1:0]   total_ff, total_in;
   logic [vpva_pkg::DROP_W-1:0]  drop_ff, drop_in;

   // Window check on the incoming tick; the offset addresses the read.
   always_comb begin
      offset  = tick - base;
      hit     = (tick >= base) && (offset < vpva_pkg::TICK_W'(levels));
      rd_addr = offset[IDX_W-1:0];
   end

   // A back-to-back add to the same level takes the value still being written.
   always_comb begin
      s1_valid_in = acc_cmd.add;
      fwd_hit_in  = acc_cmd.add && hit && s1_valid_ff && s1_hit_ff &&
                    (s1_idx_ff == offset[IDX_W-1:0]);
      operand     = fwd_hit_ff ? fwd_data_ff : rd_data;
      level_sum   = vpva_pkg::sat_level_add(operand, s1_vol_ff);
      wr_en       = s1_valid_ff && s1_hit_ff;
      wr_addr     = s1_idx_ff;
      wr_data     = level_sum;
   end

   // Running total and dropped count; a start clears both.
   always_comb begin
      total_in = total_ff;
      drop_in  = drop_ff;
      if (acc_cmd.clear) begin
         total_in = '0;
         drop_in  = '0;
      end else if (s1_valid_ff) begin
         if (s1_hit_ff) begin
            total_in = vpva_pkg::sat_sum_add(total_ff, vpva_pkg::LVL_W'(s1_vol_ff));
         end else if (drop_ff != {vpva_pkg::DROP_W{1'b1}}) begin
            drop_in = drop_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
         total_ff    <= '0;
         drop_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_hit_ff  <= fwd_hit_in;
         total_ff    <= total_in;
         drop_ff     <= drop_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      s1_hit_ff   <= hit;
      s1_idx_ff   <= offset[IDX_W-1:0];
      s1_vol_ff   <= volume;
      fwd_data_ff <= level_sum;
   end

   assign running_total = total_ff;
   assign dropped       = drop_ff;

endmodule

// ----- rtl/core/vpva_ctrl.sv -----
// Sequencer: window registers, clearing sweep, maximum scan, value area expansion, result.
// Depends on vpva_pkg for widths, codes, states and the saturating adder.
module vpva_ctrl #(
   parameter int MAX_LEVELS = vpva_pkg::MAX_LEVELS_DEF,
   localparam int IDX_W = $clog2(MAX_LEVELS),
   localparam int CNT_W = $clog2(MAX_LEVELS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [vpva_pkg::TICK_W-1:0]       req_price_tick,
   input  logic [vpva_pkg::COUNT_IN_W-1:0]   req_level_count,
   input  logic                              csr_write_enable,
   input  logic [vpva_pkg::PCT_W-1:0]        csr_write_data,
   output vpva_pkg::acc_cmd_type             acc_cmd,
   output logic [vpva_pkg::TICK_W-1:0]       base,
   output logic [CNT_W-1:0]                  levels,
   input  logic [vpva_pkg::SUM_W-1:0]        running_total,
   input  logic [vpva_pkg::DROP_W-1:0]       dropped,
   input  logic [IDX_W-1:0]                  add_rd_addr,
   input  logic                              add_wr_en,
   input  logic [IDX_W-1:0]                  add_wr_addr,
   input  logic [vpva_pkg::LVL_W-1:0]        add_wr_data,
   output logic                              mem_wr_en,
   output logic [IDX_W-1:0]                  mem_wr_addr,
   output logic [vpva_pkg::LVL_W-1:0]        mem_wr_data,
   output logic [IDX_W-1:0]                  mem_rd_addr_a,
   output logic [IDX_W-1:0]                  mem_rd_addr_b,
   input  logic [vpva_pkg::LVL_W-1:0]        mem_rd_data_a,
   input  logic [vpva_pkg::LVL_W-1:0]        mem_rd_data_b,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vpva_pkg::TICK_W-1:0]       rsp_poc_tick,
   output logic [vpva_pkg::LVL_W-1:0]        rsp_poc_volume,
   output logic [vpva_pkg::TICK_W-1:0]       rsp_area_high_tick,
   output logic [vpva_pkg::TICK_W-1:0]       rsp_area_low_tick,
   output logic [vpva_pkg::SUM_W-1:0]        rsp_area_volume,
   output logic [vpva_pkg::SUM_W-1:0]        rsp_total_volume,
   output logic [vpva_pkg::DROP_W-1:0]       rsp_dropped_count,
   output logic                              rsp_empty_res
);

   localparam int CMP_W = (CNT_W > vpva_pkg::COUNT_IN_W) ? CNT_W : vpva_pkg::COUNT_IN_W;

   vpva_pkg::state_type state_ff, state_in;

   logic [vpva_pkg::TICK_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]             levels_ff, levels_in;
   logic [vpva_pkg::PCT_W-1:0]   pct_ff;
   logic [CNT_W-1:0]             clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0]             rd_idx_ff, rd_idx_in;
   logic                         scan_vld_ff, scan_vld_in;
   logic [IDX_W-1:0]             scan_idx_ff, scan_idx_in;
   logic [vpva_pkg::LVL_W-1:0]   best_ff, best_in;
   logic [IDX_W-1:0]             poc_ff, poc_in;
   logic [vpva_pkg::SUM_W-1:0]   area_ff, area_in;
   logic [CNT_W-1:0]             up_ff, up_in;
   logic [IDX_W-1:0]             down_ff, down_in;
   logic [vpva_pkg::PROD_W-1:0]  target_ff, target_in;
   logic [vpva_pkg::PROD_W-1:0]  area100_ff, area100_in;
   logic                         empty_ff, empty_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_load;

   logic [vpva_pkg::TICK_W-1:0]  poc_tick_ff;
   logic [vpva_pkg::LVL_W-1:0]   poc_volume_ff;
   logic [vpva_pkg::TICK_W-1:0]  high_tick_ff;
   logic [vpva_pkg::TICK_W-1:0]  low_tick_ff;
   logic [vpva_pkg::SUM_W-1:0]   area_volume_ff;
   logic [vpva_pkg::SUM_W-1:0]   total_volume_ff;
   logic [vpva_pkg::DROP_W-1:0]  dropped_count_ff;
   logic                         empty_res_ff;

   logic                         accept;
   logic [CMP_W-1:0]             count_ext;
   logic [CNT_W-1:0]             count_clamped;
   logic [vpva_pkg::PCT_W-1:0]   pct_clamped;
   logic                         up_ok;
   logic                         down_ok;
   logic [vpva_pkg::LVL_W-1:0]   up_vol;
   logic [vpva_pkg::LVL_W-1:0]   down_vol;

   // A zero level count means one level; a count above the store depth saturates.
   always_comb begin
      count_ext = CMP_W'(req_level_count);
      if (count_ext == '0) begin
         count_clamped = CNT_W'(1);
      end else if (count_ext > CMP_W'(MAX_LEVELS)) begin
         count_clamped = CNT_W'(MAX_LEVELS);
      end else begin
         count_clamped = CNT_W'(count_ext);
      end
      pct_clamped = (pct_ff > vpva_pkg::PCT_FULL) ? vpva_pkg::PCT_FULL : pct_ff;
   end

   // Next state and datapath control.
   always_comb begin
      state_in    = state_ff;
      base_in     = base_ff;
      levels_in   = levels_ff;
      clr_idx_in  = clr_idx_ff;
      rd_idx_in   = rd_idx_ff;
      scan_vld_in = 1'b0;
      scan_idx_in = scan_idx_ff;
      best_in     = best_ff;
      poc_in      = poc_ff;
      area_in     = area_ff;
      up_in       = up_ff;
      down_in     = down_ff;
      target_in   = target_ff;
      area100_in  = area100_ff;
      empty_in    = empty_ff;
      rsp_load    = 1'b0;
      acc_cmd     = '0;
      req_stall   = (state_ff != vpva_pkg::ST_IDLE);
      accept      = req_valid && !req_stall;
      up_ok       = (up_ff < levels_ff);
      down_ok     = (down_ff != '0);
      up_vol      = up_ok ? mem_rd_data_a : '0;
      down_vol    = down_ok ? mem_rd_data_b : '0;

      mem_wr_en     = add_wr_en;
      mem_wr_addr   = add_wr_addr;
      mem_wr_data   = add_wr_data;
      mem_rd_addr_a = up_ff[IDX_W-1:0];
      mem_rd_addr_b = down_ff - 1'b1;

      case (state_ff)
         vpva_pkg::ST_CLEAR: begin
            // Zero one level a cycle across the window.
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_idx_ff[IDX_W-1:0];
            mem_wr_data = '0;
            if (clr_idx_ff + 1'b1 == levels_ff) begin
               state_in = vpva_pkg::ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end
         vpva_pkg::ST_IDLE: begin
            mem_rd_addr_a = add_rd_addr;
            if (accept) begin
               case (req_command)
                  vpva_pkg::CMD_START: begin
                     acc_cmd.clear = 1'b1;
                     base_in       = req_price_tick;
                     levels_in     = count_clamped;
                     clr_idx_in    = '0;
                     state_in      = vpva_pkg::ST_CLEAR;
                  end
                  vpva_pkg::CMD_ADD: begin
                     acc_cmd.add = 1'b1;
                  end
                  vpva_pkg::CMD_FINISH: begin
                     rd_idx_in = '0;
                     best_in   = '0;
                     poc_in    = '0;
                     empty_in  = 1'b0;
                     state_in  = vpva_pkg::ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         vpva_pkg::ST_SCAN: begin
            // Stream the window through port A; keep the first strict maximum.
            mem_rd_addr_a = rd_idx_ff[IDX_W-1:0];
            target_in     = vpva_pkg::PROD_W'(running_total) * vpva_pkg::PROD_W'(pct_clamped);
            if (scan_vld_ff && (mem_rd_data_a > best_ff)) begin
               best_in = mem_rd_data_a;
               poc_in  = scan_idx_ff;
            end
            if (rd_idx_ff < levels_ff) begin
               rd_idx_in   = rd_idx_ff + 1'b1;
               scan_vld_in = 1'b1;
               scan_idx_in = rd_idx_ff[IDX_W-1:0];
            end else if (running_total == '0) begin
               empty_in = 1'b1;
               state_in = vpva_pkg::ST_OUT;
            end else begin
               area_in  = vpva_pkg::SUM_W'(best_in);
               up_in    = CNT_W'(poc_in) + 1'b1;
               down_in  = poc_in;
               state_in = vpva_pkg::ST_EX_RD;
            end
         end
         vpva_pkg::ST_EX_RD: begin
            // Fetch both neighbours and scale the area by one hundred.
            area100_in = (vpva_pkg::PROD_W'(area_ff) << 6) + (vpva_pkg::PROD_W'(area_ff) << 5) +
                         (vpva_pkg::PROD_W'(area_ff) << 2);
            state_in   = vpva_pkg::ST_EX_STEP;
         end
         vpva_pkg::ST_EX_STEP: begin
            // Grow toward the larger neighbour, upward on a tie.
            if ((area100_ff < target_ff) && (up_ok || down_ok)) begin
               if (up_ok && ((up_vol >= down_vol) || !down_ok)) begin
                  area_in = vpva_pkg::sat_sum_add(area_ff, up_vol);
                  up_in   = up_ff + 1'b1;
               end else begin
                  area_in = vpva_pkg::sat_sum_add(area_ff, down_vol);
                  down_in = down_ff - 1'b1;
               end
               state_in = vpva_pkg::ST_EX_RD;
            end else begin
               state_in = vpva_pkg::ST_OUT;
            end
         end
         vpva_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = vpva_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vpva_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vpva_pkg::ST_CLEAR;
         base_ff      <= '0;
         levels_ff    <= CNT_W'(1);
         clr_idx_ff   <= '0;
         pct_ff       <= vpva_pkg::PCT_RESET;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         levels_ff    <= levels_in;
         clr_idx_ff   <= clr_idx_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            pct_ff <= csr_write_data;
         end
      end
   end

   // Working registers of the scan and the expansion.
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      scan_idx_ff <= scan_idx_in;
      best_ff     <= best_in;
      poc_ff      <= poc_in;
      area_ff     <= area_in;
      up_ff       <= up_in;
      down_ff     <= down_in;
      target_ff   <= target_in;
      area100_ff  <= area100_in;
      empty_ff    <= empty_in;
   end

   // Result register; an empty profile reports zeros apart from the dropped count.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         dropped_count_ff <= dropped;
         empty_res_ff     <= empty_ff;
         if (empty_ff) begin
            poc_tick_ff     <= '0;
            poc_volume_ff   <= '0;
            high_tick_ff    <= '0;
            low_tick_ff     <= '0;
            area_volume_ff  <= '0;
            total_volume_ff <= '0;
         end else begin
            poc_tick_ff     <= base_ff + vpva_pkg::TICK_W'(poc_ff);
            poc_volume_ff   <= best_ff;
            high_tick_ff    <= base_ff + vpva_pkg::TICK_W'(up_ff) - 1'b1;
            low_tick_ff     <= base_ff + vpva_pkg::TICK_W'(down_ff);
            area_volume_ff  <= area_ff;
            total_volume_ff <= running_total;
         end
      end
   end

   assign base               = base_ff;
   assign levels             = levels_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_poc_tick       = poc_tick_ff;
   assign rsp_poc_volume     = poc_volume_ff;
   assign rsp_area_high_tick = high_tick_ff;
   assign rsp_area_low_tick  = low_tick_ff;
   assign rsp_area_volume    = area_volume_ff;
   assign rsp_total_volume   = total_volume_ff;
   assign rsp_dropped_count  = dropped_count_ff;
   assign rsp_empty_res      = empty_res_ff;

endmodule

// ----- rtl/core/vpva_port_checker.sv -----
// Port checker for the volume profile block, bound to the top level.
// Depends on vpva_pkg and the assertion macro header.
`include "volume_profile_value_area_assert.svh"

module vpva_port_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [vpva_pkg::TICK_W-1:0]       rsp_poc_tick,
   input  logic [vpva_pkg::LVL_W-1:0]        rsp_poc_volume,
   input  logic [vpva_pkg::SUM_W-1:0]        rsp_area_volume,
   input  logic [vpva_pkg::SUM_W-1:0]        rsp_total_volume,
   input  logic [vpva_pkg::DROP_W-1:0]       rsp_dropped_count,
   input  logic                              rsp_empty_res
);

   // A stalled result transaction stays and keeps its payload.
   `VPVA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_poc_tick) && $stable(rsp_area_volume) && $stable(rsp_dropped_count))

   // An empty profile reports zero volumes.
   `VPVA_ASSERT_NOW(a_empty_zero, rsp_valid && rsp_empty_res, rsp_total_volume == '0 && rsp_area_volume == '0 && rsp_poc_volume == '0)

   // A filled profile has the point of control inside the area and the area inside the total.
   `VPVA_ASSERT_NOW(a_area_order, rsp_valid && !rsp_empty_res, rsp_total_volume != '0 && rsp_area_volume >= 48'(rsp_poc_volume) && rsp_total_volume >= rsp_area_volume)

   // A finish transaction always leaves the block busy with its scan in the next cycle.
   `VPVA_ASSERT_NEXT(a_finish_busy, req_valid && !req_stall && req_command == vpva_pkg::CMD_FINISH, req_stall)

endmodule

bind volume_profile_value_area vpva_port_checker u_port_checker (.*);

// ----- verif/volume_profile_value_area_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for volume_profile_value_area: a directed stimulus table, a
// saturation run and random profiles, checked against typed rows or a predictor in this file.
// Depends on vpva_pkg and the volume_profile_value_area RTL.
module volume_profile_value_area_tb;

   localparam int TICK_W        = vpva_pkg::TICK_W;
   localparam int COUNT_IN_W    = vpva_pkg::COUNT_IN_W;
   localparam int VOL_W         = vpva_pkg::VOL_W;
   localparam int LVL_W         = vpva_pkg::LVL_W;
   localparam int SUM_W         = vpva_pkg::SUM_W;
   localparam int DROP_W        = vpva_pkg::DROP_W;
   localparam int PCT_W         = vpva_pkg::PCT_W;
   localparam int LEVELS        = vpva_pkg::MAX_LEVELS_DEF;
   localparam int SETTLE_CYCLES = 300;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int PHASE_ITEMS   = 145;
   localparam int SAT_ADDS      = 300;
   localparam int unsigned DROP_CAP = 65535;
   localparam longint unsigned LEVEL_CAP = 64'hFF_FFFF_FFFF;
   localparam longint unsigned SUM_CAP   = 64'hFFFF_FFFF_FFFF;

   // One input transaction and one result transaction, at the block's widths.
   typedef struct packed {
      vpva_pkg::cmd_type       command;
      logic [TICK_W-1:0]       tick;
      logic [COUNT_IN_W-1:0]   count;
      logic [VOL_W-1:0]        volume;
   } trade_request;

   typedef struct packed {
      logic [TICK_W-1:0]  poc_tick;
      logic [LVL_W-1:0]   poc_volume;
      logic [TICK_W-1:0]  area_high_tick;
      logic [TICK_W-1:0]  area_low_tick;
      logic [SUM_W-1:0]   area_volume;
      logic [SUM_W-1:0]   total_volume;
      logic [DROP_W-1:0]  dropped_count;
      logic               empty_res;
   } profile_report;

   typedef struct {
      trade_request   req;
      bit             typed;
      profile_report  want;
   } directed_row;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [1:0]              req_command;
   logic [TICK_W-1:0]       req_price_tick;
   logic [COUNT_IN_W-1:0]   req_level_count;
   logic [VOL_W-1:0]        req_volume;
   logic                    csr_write_enable;
   logic [PCT_W-1:0]        csr_write_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [TICK_W-1:0]       rsp_poc_tick;
   logic [LVL_W-1:0]        rsp_poc_volume;
   logic [TICK_W-1:0]       rsp_area_high_tick;
   logic [TICK_W-1:0]       rsp_area_low_tick;
   logic [SUM_W-1:0]        rsp_area_volume;
   logic [SUM_W-1:0]        rsp_total_volume;
   logic [DROP_W-1:0]       rsp_dropped_count;
   logic                    rsp_empty_res;

   // Predictor state: histogram, window and percent register.
   longint unsigned   bin_volume [LEVELS];
   logic [TICK_W-1:0] window_base;
   int unsigned       window_span;
   longint unsigned   traded_total;
   int unsigned       dropped_tally;
   logic [PCT_W-1:0]  area_percent;

   profile_report pending_reports [$];
   int            fail_count = 0;
   int unsigned   issued = 0;
   bit            no_idling = 1'b0;

   // Directed rows: reset state, window extremes, dropped ticks, ties and the empty profile.
   directed_row directed_rows [26] = '{
      '{'{vpva_pkg::CMD_FINISH, 20'h00000, 9'h000, 32'h0}, 1'b1,
        '{20'h0, 40'h0, 20'h0, 20'h0, 48'h0, 48'h0, 16'd0, 1'b1}},
      '{'{vpva_pkg::CMD_ADD,    20'h00000, 9'h000, 32'd5}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'h00001, 9'h000, 32'd7}, 1'b0, '0},
      '{'{vpva_pkg::CMD_FINISH, 20'h00000, 9'h000, 32'h0}, 1'b1,
        '{20'h0, 40'd5, 20'h0, 20'h0, 48'd5, 48'd5, 16'd1, 1'b0}},
      '{'{vpva_pkg::CMD_NONE,   20'hFFFFF, 9'h1FF, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{vpva_pkg::CMD_START,  20'hFFFFF, 9'h000, 32'h0}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'hFFFFF, 9'h000, 32'hFFFF_FFFF}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'h00000, 9'h000, 32'd1}, 1'b0, '0},
      '{'{vpva_pkg::CMD_FINISH, 20'h00000, 9'h000, 32'h0}, 1'b1,
        '{20'hFFFFF, 40'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 48'hFFFF_FFFF, 48'hFFFF_FFFF,
          16'd1, 1'b0}},
      '{'{vpva_pkg::CMD_START,  20'hFFFF0, 9'h1FF, 32'h0}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'hFFFF0, 9'h000, 32'd100}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'hFFFFF, 9'h000, 32'd100}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'hFFFF8, 9'h000, 32'd300}, 1'b0, '0},
      '{'{vpva_pkg::CMD_FINISH, 20'h00000, 9'h000, 32'h0}, 1'b0, '0},
      '{'{vpva_pkg::CMD_START,  20'h00100, 9'h100, 32'h0}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'h001FF, 9'h000, 32'd9}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'h00100, 9'h000, 32'd9}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'h00200, 9'h000, 32'd9}, 1'b0, '0},
      '{'{vpva_pkg::CMD_FINISH, 20'h00000, 9'h000, 32'h0}, 1'b0, '0},
      '{'{vpva_pkg::CMD_START,  20'h55555, 9'h0AA, 32'h0}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'h555F0, 9'h000, 32'h0}, 1'b0, '0},
      '{'{vpva_pkg::CMD_FINISH, 20'h00000, 9'h000, 32'h0}, 1'b1,
        '{20'h0, 40'h0, 20'h0, 20'h0, 48'h0, 48'h0, 16'd0, 1'b1}},
      '{'{vpva_pkg::CMD_START,  20'hAAAAA, 9'h003, 32'h0}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'hAAAAC, 9'h000, 32'hAAAA_AAAA}, 1'b0, '0},
      '{'{vpva_pkg::CMD_ADD,    20'hAAAAA, 9'h000, 32'h5555_5555}, 1'b0, '0},
      '{'{vpva_pkg::CMD_FINISH, 20'h00000, 9'h000, 32'h0}, 1'b0, '0}
   };

   volume_profile_value_area i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_price_tick     (req_price_tick),
      .req_level_count    (req_level_count),
      .req_volume         (req_volume),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_poc_tick       (rsp_poc_tick),
      .rsp_poc_volume     (rsp_poc_volume),
      .rsp_area_high_tick (rsp_area_high_tick),
      .rsp_area_low_tick  (rsp_area_low_tick),
      .rsp_area_volume    (rsp_area_volume),
      .rsp_total_volume   (rsp_total_volume),
      .rsp_dropped_count  (rsp_dropped_count),
      .rsp_empty_res      (rsp_empty_res)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Addition that clips at the given ceiling.
   function automatic longint unsigned capped_sum(input longint unsigned a,
                                                  input longint unsigned b,
                                                  input longint unsigned cap);
      longint unsigned s;
      s = a + b;
      return (s > cap) ? cap : s;
   endfunction

   // Profile predictor: applies one accepted transaction, returns the report it causes.
   function automatic void profile_step(input trade_request r, output bit has_report,
                                        output profile_report rep);
      int unsigned     span, offset, poc, up, down, i;
      longint unsigned best, area, uv, dv, pct;
      has_report = 1'b0;
      rep = '0;
      case (r.command)
         vpva_pkg::CMD_START: begin
            span = r.count;
            if (span == 0) span = 1;
            if (span > LEVELS) span = LEVELS;
            foreach (bin_volume[k]) bin_volume[k] = 0;
            window_base = r.tick;
            window_span = span;
            traded_total = 0;
            dropped_tally = 0;
         end
         vpva_pkg::CMD_ADD: begin
            offset = 32'(r.tick) - 32'(window_base);
            if (r.tick >= window_base && offset < window_span) begin
               bin_volume[offset] = capped_sum(bin_volume[offset], r.volume, LEVEL_CAP);
               traded_total = capped_sum(traded_total, r.volume, SUM_CAP);
            end else if (dropped_tally < DROP_CAP) begin
               dropped_tally++;
            end
         end
         vpva_pkg::CMD_FINISH: begin
            has_report = 1'b1;
            rep.dropped_count = DROP_W'(dropped_tally);
            if (traded_total == 0) begin
               rep.empty_res = 1'b1;
            end else begin
               // First, lowest level holding the most volume.
               best = 0;
               poc = 0;
               for (i = 0; i < window_span; i++) begin
                  if (bin_volume[i] > best) begin
                     best = bin_volume[i];
                     poc = i;
                  end
               end
               // Grow toward the larger neighbour; ties and an exhausted lower side go up.
               pct = (area_percent > vpva_pkg::PCT_FULL) ? vpva_pkg::PCT_FULL : area_percent;
               area = best;
               up = poc + 1;
               down = poc;
               while (area * 100 < traded_total * pct && (up < window_span || down > 0)) begin
                  uv = (up < window_span) ? bin_volume[up] : 0;
                  dv = (down > 0) ? bin_volume[down - 1] : 0;
                  if (up < window_span && (uv >= dv || down == 0)) begin
                     area = capped_sum(area, uv, SUM_CAP);
                     up++;
                  end else begin
                     area = capped_sum(area, dv, SUM_CAP);
                     down--;
                  end
               end
               rep.poc_tick = TICK_W'(32'(window_base) + poc);
               rep.poc_volume = LVL_W'(best);
               rep.area_high_tick = TICK_W'(32'(window_base) + up - 1);
               rep.area_low_tick = TICK_W'(32'(window_base) + down);
               rep.area_volume = SUM_W'(area);
               rep.total_volume = SUM_W'(traded_total);
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Drives one transaction, possibly after an idle burst, and records its expected report.
   task automatic send_request(input trade_request r, input bit typed = 1'b0,
                               input profile_report want = '0);
      bit            gives;
      profile_report calc;
      int            gap;
      @(negedge clock);
      if (!no_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 9);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= r.command;
      req_price_tick <= r.tick;
      req_level_count <= r.count;
      req_volume <= r.volume;
      do @(posedge clock); while (req_stall);
      profile_step(r, gives, calc);
      if (gives) pending_reports.push_back(typed ? want : calc);
      if (r.command != vpva_pkg::CMD_NONE) issued++;
   endtask

   // Waits until the block is idle, then writes the value area percent.
   task automatic write_percent(input logic [PCT_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      area_percent = value;
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Result monitor: each accepted transaction is compared with the oldest expectation.
   always @(posedge clock) begin
      profile_report want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result transaction with none expected, actual poc_tick %0h",
                     $time, rsp_poc_tick);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("poc_tick", want.poc_tick, rsp_poc_tick);
            check_field("poc_volume", want.poc_volume, rsp_poc_volume);
            check_field("area_high_tick", want.area_high_tick, rsp_area_high_tick);
            check_field("area_low_tick", want.area_low_tick, rsp_area_low_tick);
            check_field("area_volume", want.area_volume, rsp_area_volume);
            check_field("total_volume", want.total_volume, rsp_total_volume);
            check_field("dropped_count", want.dropped_count, rsp_dropped_count);
            check_field("empty_res", want.empty_res, rsp_empty_res);
         end
      end
   end

   // Receiver back-pressure in random bursts, with long quiet stretches.
   initial begin
      int quiet;
      rsp_stall = 1'b0;
      forever begin
         quiet = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
         repeat (quiet) @(negedge clock);
         if (!no_idling && $urandom_range(0, 1) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus: reset, directed table, saturation run, random phases, drain.
   initial begin
      trade_request      r;
      logic [TICK_W-1:0] base;
      logic [PCT_W-1:0]  set_points [5];
      logic [PCT_W-1:0]  pct;
      int unsigned       span, adds, target, waited;
      set_points = '{7'd1, 7'd0, 7'd127, 7'd50, vpva_pkg::PCT_RESET};
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = vpva_pkg::CMD_START;
      req_price_tick = '0;
      req_level_count = '0;
      req_volume = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      foreach (bin_volume[k]) bin_volume[k] = 0;
      window_base = '0;
      window_span = 1;
      traded_total = 0;
      dropped_tally = 0;
      area_percent = vpva_pkg::PCT_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      // Saturation run: the lowest level clips while some ticks fall outside the window.
      write_percent(vpva_pkg::PCT_FULL);
      no_idling = 1'b1;
      r = '{vpva_pkg::CMD_START, TICK_W'($urandom_range(0, 20'hFFFF0)), 9'd4, 32'h0};
      base = r.tick;
      send_request(r);
      for (int n = 0; n < SAT_ADDS; n++) begin
         r.command = vpva_pkg::CMD_ADD;
         r.volume = '1;
         r.tick = (n % 8 != 7) ? base : TICK_W'(32'(base) + 4 + n % 997);
         send_request(r);
      end
      r.command = vpva_pkg::CMD_FINISH;
      send_request(r);
      r = '{vpva_pkg::CMD_ADD, TICK_W'(base - 1), 9'd0, 32'd1};
      send_request(r);
      r.command = vpva_pkg::CMD_FINISH;
      send_request(r);
      no_idling = 1'b0;

      // Random phases, each after a fresh percent write; the last one runs without idling.
      for (int p = 0; p < 8; p++) begin
         pct = (p < 5) ? set_points[p] : PCT_W'($urandom_range(0, 127));
         write_percent(pct);
         if (p == 7) no_idling = 1'b1;
         target = issued + PHASE_ITEMS;
         while (issued < target) begin
            if ($urandom_range(0, 99) < 85) begin
               // Well-formed profile: start, adds mostly inside the window, finish.
               r.command = vpva_pkg::CMD_START;
               r.tick = TICK_W'($urandom);
               r.count = ($urandom_range(0, 9) == 0) ? COUNT_IN_W'($urandom_range(13, 511))
                                                    : COUNT_IN_W'($urandom_range(0, 12));
               r.volume = $urandom;
               span = (r.count == 0) ? 1 : ((r.count > LEVELS) ? LEVELS : r.count);
               base = r.tick;
               send_request(r);
               adds = $urandom_range(0, 20);
               repeat (adds) begin
                  r.command = vpva_pkg::CMD_ADD;
                  r.count = COUNT_IN_W'($urandom);
                  if ($urandom_range(0, 99) < 85) begin
                     r.tick = TICK_W'(32'(base) + $urandom_range(0, span - 1));
                  end else begin
                     case ($urandom_range(0, 2))
                        0: r.tick = TICK_W'(32'(base) - 1);
                        1: r.tick = TICK_W'(32'(base) + span);
                        default: r.tick = TICK_W'($urandom);
                     endcase
                  end
                  case ($urandom_range(0, 3))
                     0: r.volume = VOL_W'($urandom_range(0, 3));
                     1: r.volume = VOL_W'($urandom_range(0, 1000));
                     2: r.volume = $urandom;
                     default: r.volume = '1;
                  endcase
                  send_request(r);
               end
               r.command = vpva_pkg::CMD_FINISH;
               r.tick = TICK_W'($urandom);
               send_request(r);
               // A repeated finish must report the same profile.
               if ($urandom_range(0, 4) == 0) send_request(r);
            end else begin
               // Noise: any command with arbitrary fields.
               r.command = vpva_pkg::cmd_type'($urandom_range(0, 3));
               r.tick = TICK_W'($urandom);
               r.count = COUNT_IN_W'($urandom);
               r.volume = $urandom;
               send_request(r);
            end
         end
      end

      // Drain the remaining reports, then let the block settle.
      @(negedge clock);
      req_valid <= 1'b0;
      for (waited = 0; waited < DRAIN_LIMIT && pending_reports.size() != 0; waited++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $display("%0t: %0d expected result transactions never arrived",
                  $time, pending_reports.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(80_000_000);
      $display("%0t: timeout", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule
